>>> design/sbr_pkg.sv
// sbr_pkg: shared types and constants for the scaled blit raster-op unit
// no dependencies
package sbr_pkg;

   localparam int MAX_SRC_W = 64;
   localparam int MAX_SRC_H = 64;
   localparam int SCREEN_W  = 320;
   localparam int SCREEN_H  = 240;
   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W = 12;
   localparam int DIV_STEPS = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 11;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;

   localparam logic [2:0] ROP_COPY     = 3'd0;
   localparam logic [2:0] ROP_OR       = 3'd1;
   localparam logic [2:0] ROP_AND      = 3'd2;
   localparam logic [2:0] ROP_XOR      = 3'd3;
   localparam logic [2:0] ROP_INV_COPY = 3'd4;

   localparam logic [2:0] REG_SRC_W   = 3'd0;
   localparam logic [2:0] REG_SRC_H   = 3'd1;
   localparam logic [2:0] REG_TGT_W   = 3'd2;
   localparam logic [2:0] REG_TGT_H   = 3'd3;
   localparam logic [2:0] REG_SCALE   = 3'd4;
   localparam logic [2:0] REG_RASTER  = 3'd5;
   localparam logic [2:0] REG_ORIGIN_X = 3'd6;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd7;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_LARGE = 2'd2;

   typedef struct packed {
      logic        op;
      logic [11:0] load_index;
      logic [15:0] load_pixel;
      logic [9:0]  offset_x;
      logic [9:0]  offset_y;
      logic [15:0] frame_pixel;
   } req_type;

   typedef struct packed {
      logic signed [11:0] screen_x;
      logic signed [11:0] screen_y;
      logic [15:0]        out_color;
      logic               draw;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [6:0]         source_width;
      logic [6:0]         source_height;
      logic [9:0]         target_width;
      logic [9:0]         target_height;
      logic               scale_enable;
      logic [2:0]         raster_mode;
      logic signed [10:0] origin_x;
      logic signed [10:0] origin_y;
   } cfg_type;

   // classified item passed from front to back
   typedef struct packed {
      logic        op;
      logic [11:0] load_index;
      logic [15:0] load_pixel;
      logic [16:0] num_x;   // ox * w
      logic [16:0] num_y;
      logic [9:0]  den_x;
      logic [9:0]  den_y;
      logic [9:0]  offset_x;
      logic [9:0]  offset_y;
      logic [15:0] frame_pixel;
      logic signed [11:0] screen_x;
      logic signed [11:0] screen_y;
      logic        draw;
      logic [1:0]  status;
   } cmd_type;

   function automatic logic [15:0] raster(logic [2:0] mode, logic [15:0] src,
                                          logic [15:0] dst);
      logic [15:0] r;
      case (mode)
         ROP_OR:       r = src | dst;
         ROP_AND:      r = src & dst;
         ROP_XOR:      r = src ^ dst;
         ROP_INV_COPY: r = ~src;
         default:      r = src;
      endcase
      return r;
   endfunction

endpackage

>>> design/sbr_front.sv
// sbr_front: configuration registers and item classification
// depends on sbr_pkg
module sbr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [10:0]       csr_wdata,
   input  sbr_pkg::req_type  in_data,
   output sbr_pkg::cfg_type  cfg,
   output sbr_pkg::cmd_type  cmd
);
   import sbr_pkg::*;

   cfg_type cfg_ff;
   logic [9:0] dw, dh;
   logic ok_size, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{source_width: 7'd0, source_height: 7'd0, target_width: 10'd1,
                     target_height: 10'd1, scale_enable: 1'b0, raster_mode: ROP_COPY,
                     origin_x: 11'sd0, origin_y: 11'sd0};
      end else if (csr_we) begin
         case (csr_index)
            REG_SRC_W:    cfg_ff.source_width  <= csr_wdata[6:0];
            REG_SRC_H:    cfg_ff.source_height <= csr_wdata[6:0];
            REG_TGT_W:    cfg_ff.target_width  <= csr_wdata[9:0];
            REG_TGT_H:    cfg_ff.target_height <= csr_wdata[9:0];
            REG_SCALE:    cfg_ff.scale_enable  <= csr_wdata[0];
            REG_RASTER:   cfg_ff.raster_mode   <= csr_wdata[2:0];
            REG_ORIGIN_X: cfg_ff.origin_x      <= csr_wdata;
            REG_ORIGIN_Y: cfg_ff.origin_y      <= csr_wdata;
            default: ;
         endcase
      end
   end
   assign cfg = cfg_ff;

   always_comb begin
      dw = cfg_ff.scale_enable ? cfg_ff.target_width : {3'd0, cfg_ff.source_width};
      dh = cfg_ff.scale_enable ? cfg_ff.target_height : {3'd0, cfg_ff.source_height};
      empty = (cfg_ff.source_width == 7'd0) || (cfg_ff.source_height == 7'd0);
      ok_size = ({3'd0, cfg_ff.source_width} <= 10'(MAX_SRC_W))
             && ({3'd0, cfg_ff.source_width} <= 10'(SCREEN_W))
             && ({3'd0, cfg_ff.source_height} <= 10'(MAX_SRC_H))
             && ({3'd0, cfg_ff.source_height} <= 10'(SCREEN_H))
             && ({1'b0, dw} <= 11'(SCREEN_W)) && ({1'b0, dh} <= 11'(SCREEN_H));
      cmd.op          = in_data.op;
      cmd.load_index  = in_data.load_index;
      cmd.load_pixel  = in_data.load_pixel;
      cmd.num_x       = 17'(in_data.offset_x) * 17'(cfg_ff.source_width);
      cmd.num_y       = 17'(in_data.offset_y) * 17'(cfg_ff.source_height);
      cmd.den_x       = dw;
      cmd.den_y       = dh;
      cmd.offset_x    = in_data.offset_x;
      cmd.offset_y    = in_data.offset_y;
      cmd.frame_pixel = in_data.frame_pixel;
      cmd.screen_x    = 12'(cfg_ff.origin_x) + $signed({2'b00, in_data.offset_x});
      cmd.screen_y    = 12'(cfg_ff.origin_y) + $signed({2'b00, in_data.offset_y});
      cmd.draw        = 1'b0;
      cmd.status      = ST_OK;
      if (empty) cmd.status = ST_EMPTY;
      else if (!ok_size) cmd.status = ST_LARGE;
      else if (in_data.offset_x < dw && in_data.offset_y < dh) cmd.draw = 1'b1;
      if (!in_data.op) begin
         cmd.screen_x = '0;
         cmd.screen_y = '0;
         cmd.status = ST_OK;
         cmd.draw = 1'b0;
      end
   end
endmodule

>>> design/sbr_back.sv
// sbr_back: pipelined nearest-neighbor division, image store and raster op
// depends on sbr_pkg
module sbr_back (
   input  logic             clock,
   input  logic             reset,
   input  sbr_pkg::cfg_type cfg,
   input  logic             in_valid,
   input  sbr_pkg::cmd_type in_cmd,
   output logic             in_ready,
   output logic             out_valid,
   output sbr_pkg::rsp_type out_data,
   input  logic             out_ready
);
   import sbr_pkg::*;

   // one restoring-divide bit per stage; quotient < 1024
   typedef struct packed {
      logic        op;
      logic [11:0] load_index;
      logic [15:0] load_pixel;
      logic [16:0] rem_x, rem_y;
      logic [9:0]  q_x, q_y;
      logic [9:0]  den_x, den_y;
      logic [9:0]  offset_x, offset_y;
      logic [15:0] frame_pixel;
      logic signed [11:0] screen_x, screen_y;
      logic        draw;
      logic [1:0]  status;
   } stg_type;

   logic    stall;
   logic    v_ff [DIV_STEPS+1];
   stg_type s_ff [DIV_STEPS+1];
   stg_type s_in [DIV_STEPS+1];

   // small output fifo; when it is full and a result is ready to enter it, the whole pipe waits
   rsp_type fifo_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wp_ff, rp_ff;
   logic [OUT_PTR_W:0]   cnt_ff;

   logic [15:0] mem [STORE_DEPTH];
   logic [11:0] addr_ff;
   logic        a_v_ff, r_v_ff;
   stg_type     a_ff, r_ff;
   logic [15:0] rd_ff;
   logic [11:0] addr_in;
   rsp_type     res;
   logic        push_f, pop_f;

   // whole pipe freezes when the output side is backed up
   assign stall = (cnt_ff == (OUT_PTR_W+1)'(OUT_DEPTH)) && r_v_ff;
   assign in_ready = !stall;

   always_comb begin
      s_in[0] = '0;
      s_in[0].op = in_cmd.op;
      s_in[0].load_index = in_cmd.load_index;
      s_in[0].load_pixel = in_cmd.load_pixel;
      s_in[0].rem_x = in_cmd.num_x;
      s_in[0].rem_y = in_cmd.num_y;
      s_in[0].den_x = in_cmd.den_x;
      s_in[0].den_y = in_cmd.den_y;
      s_in[0].offset_x = in_cmd.offset_x;
      s_in[0].offset_y = in_cmd.offset_y;
      s_in[0].frame_pixel = in_cmd.frame_pixel;
      s_in[0].screen_x = in_cmd.screen_x;
      s_in[0].screen_y = in_cmd.screen_y;
      s_in[0].draw = in_cmd.draw;
      s_in[0].status = in_cmd.status;
      // compare at full width so the shifted divisor never wraps
      for (int i = 1; i <= DIV_STEPS; i++) begin
         s_in[i] = s_ff[i-1];
         if ({10'd0, s_ff[i-1].rem_x} >= (27'(s_ff[i-1].den_x) << (DIV_STEPS - i))) begin
            s_in[i].rem_x = 17'({10'd0, s_ff[i-1].rem_x}
                                - (27'(s_ff[i-1].den_x) << (DIV_STEPS - i)));
            s_in[i].q_x[DIV_STEPS-i] = 1'b1;
         end
         if ({10'd0, s_ff[i-1].rem_y} >= (27'(s_ff[i-1].den_y) << (DIV_STEPS - i))) begin
            s_in[i].rem_y = 17'({10'd0, s_ff[i-1].rem_y}
                                - (27'(s_ff[i-1].den_y) << (DIV_STEPS - i)));
            s_in[i].q_y[DIV_STEPS-i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) v_ff[i] <= 1'b0;
         a_v_ff <= 1'b0;
         r_v_ff <= 1'b0;
      end else if (!stall) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= DIV_STEPS; i++) v_ff[i] <= v_ff[i-1];
         a_v_ff <= v_ff[DIV_STEPS];
         r_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s_ff[0] <= s_in[0];
         for (int i = 1; i <= DIV_STEPS; i++) s_ff[i] <= s_in[i];
         a_ff <= s_ff[DIV_STEPS];
         addr_ff <= addr_in;
         r_ff <= a_ff;
      end
   end

   // address multiply sits on its own stage
   always_comb begin
      logic [9:0] si, sj;
      si = cfg.scale_enable ? s_ff[DIV_STEPS].q_x : s_ff[DIV_STEPS].offset_x;
      sj = cfg.scale_enable ? s_ff[DIV_STEPS].q_y : s_ff[DIV_STEPS].offset_y;
      addr_in = 12'(17'(sj) * 17'(cfg.source_width) + 17'(si));
   end

   // store: write loads at stage a, read composes at stage a
   always_ff @(posedge clock) begin
      if (!stall && a_v_ff) begin
         if (!a_ff.op) mem[a_ff.load_index] <= a_ff.load_pixel;
         rd_ff <= mem[addr_ff];
      end
   end

   always_comb begin
      res.screen_x = r_ff.screen_x;
      res.screen_y = r_ff.screen_y;
      res.draw = r_ff.draw;
      res.status = r_ff.status;
      res.out_color = r_ff.draw ? raster(cfg.raster_mode, rd_ff, r_ff.frame_pixel) : 16'd0;
   end

   assign push_f = r_v_ff && !stall;
   assign pop_f = out_valid && out_ready;
   assign out_valid = cnt_ff != '0;
   assign out_data = fifo_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_f) wp_ff <= wp_ff + 1'b1;
         if (pop_f) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (OUT_PTR_W+1)'(push_f) - (OUT_PTR_W+1)'(pop_f);
      end
   end

   always_ff @(posedge clock) begin
      if (push_f) fifo_ff[wp_ff] <= res;
   end
endmodule

>>> design/sbr_queue.sv
// sbr_queue: two-entry queue between front and back
// depends on sbr_pkg
module sbr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  sbr_pkg::cmd_type in_data,
   output logic             in_full,
   output logic             out_valid,
   output sbr_pkg::cmd_type out_data,
   input  logic             out_ready
);
   import sbr_pkg::*;

   cmd_type q_ff [2];
   logic    wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_full = cnt_ff == 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = q_ff[rp_ff];
   assign push = in_valid && !in_full;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= in_data;
   end
endmodule

>>> design/scaled_blit_raster_op_unit.sv
// scaled_blit_raster_op_unit: top level of the scaled sprite blitter
// depends on sbr_pkg, sbr_front, sbr_queue, sbr_back
//
// channel   direction  handshake          payload
// req       in         push / full        sbr_pkg::req_type
// rsp       out        pop / empty        sbr_pkg::rsp_type
// csr       in         csr_we             csr_index, csr_wdata
//
// one item per cycle sustained while the output fifo is not backed up; a result reaches
// the rsp ports after its req beat passes the middle queue, input stage, ten divider
// stages, address, store read and output fifo.
// reset is synchronous and clears control state; the image store is not cleared.
// a full output fifo freezes the back pipe, the middle queue then raises full.
module scaled_blit_raster_op_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  sbr_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output sbr_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [10:0]       csr_wdata
);
   import sbr_pkg::*;

   cfg_type cfg;
   cmd_type f_cmd, q_cmd;
   logic    q_valid, b_ready, b_valid;

   sbr_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .in_data(req_data), .cfg, .cmd(f_cmd)
   );

   sbr_queue u_queue (
      .clock, .reset, .in_valid(push), .in_data(f_cmd), .in_full(full),
      .out_valid(q_valid), .out_data(q_cmd), .out_ready(b_ready)
   );

   sbr_back u_back (
      .clock, .reset, .cfg, .in_valid(q_valid && b_ready), .in_cmd(q_cmd),
      .in_ready(b_ready), .out_valid(b_valid), .out_data(rsp_data), .out_ready(pop)
   );

   assign empty = !b_valid;
endmodule

>>> design/sbr_checker.sv
// sbr_checker: port-level checks for the blitter top level
// depends on sbr_pkg
module sbr_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input sbr_pkg::rsp_type rsp_data
);
   import sbr_pkg::*;

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("empty not set after reset");
   a_full_after_reset: assert property (@(posedge clock) reset |=> !full)
      else $error("full set after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting beat changed");
   a_nodraw_color: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.draw) |-> rsp_data.out_color == 16'd0)
      else $error("color on a non-draw beat");
   a_status_draw: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status != ST_OK) |-> !rsp_data.draw)
      else $error("draw with error status");
endmodule

bind scaled_blit_raster_op_unit sbr_checker u_checker (
   .clock, .reset, .full, .empty, .pop, .rsp_data
);

>>> dv/tb_top.sv
// tb_top: self-checking testbench for scaled_blit_raster_op_unit
// depends on sbr_pkg and the unit's rtl; predicts each result beat in a small scoreboard
`timescale 1ns / 1ps

module tb_top;
   import sbr_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE = 40;
   localparam int ITEM_GOAL = 1350;

   class blit_scoreboard;
      cfg_type     cfg;
      logic [15:0] image[STORE_DEPTH];
      bit          seen[STORE_DEPTH];
      rsp_type     pending_rsp[$];
      int          errors;
      int          composes;
      int          draws;

      function void set_reg(logic [2:0] idx, logic [10:0] d);
         case (idx)
            REG_SRC_W:    cfg.source_width  = d[6:0];
            REG_SRC_H:    cfg.source_height = d[6:0];
            REG_TGT_W:    cfg.target_width  = d[9:0];
            REG_TGT_H:    cfg.target_height = d[9:0];
            REG_SCALE:    cfg.scale_enable  = d[0];
            REG_RASTER:   cfg.raster_mode   = d[2:0];
            REG_ORIGIN_X: cfg.origin_x      = d;
            default:      cfg.origin_y      = d;
         endcase
      endfunction

      // returns 1 when the compose beat reads the store, with the address
      function bit locate(req_type r, output logic [11:0] a, output logic [1:0] st);
         int w, h, dw, dh, si, sj;
         w  = cfg.source_width;
         h  = cfg.source_height;
         dw = cfg.scale_enable ? int'(cfg.target_width) : w;
         dh = cfg.scale_enable ? int'(cfg.target_height) : h;
         st = ST_OK;
         a  = '0;
         if (w == 0 || h == 0) begin
            st = ST_EMPTY;
            return 0;
         end
         if (w > MAX_SRC_W || w > SCREEN_W || h > MAX_SRC_H || h > SCREEN_H ||
             dw > SCREEN_W || dh > SCREEN_H) begin
            st = ST_LARGE;
            return 0;
         end
         if (int'(r.offset_x) >= dw || int'(r.offset_y) >= dh) return 0;
         si = cfg.scale_enable ? (int'(r.offset_x) * w) / dw : int'(r.offset_x);
         sj = cfg.scale_enable ? (int'(r.offset_y) * h) / dh : int'(r.offset_y);
         a  = 12'(sj * w + si);
         return 1;
      endfunction

      function void note_beat(req_type r);
         rsp_type     p;
         logic [11:0] a;
         logic [1:0]  st;
         logic [15:0] src;
         p = '0;
         if (!r.op) begin
            image[r.load_index] = r.load_pixel;
            seen[r.load_index]  = 1;
         end else begin
            composes++;
            p.screen_x = 12'(int'(cfg.origin_x) + int'(r.offset_x));
            p.screen_y = 12'(int'(cfg.origin_y) + int'(r.offset_y));
            p.draw = locate(r, a, st);
            p.status = st;
            if (p.draw) begin
               draws++;
               src = image[a];
               case (cfg.raster_mode)
                  ROP_OR:       p.out_color = src | r.frame_pixel;
                  ROP_AND:      p.out_color = src & r.frame_pixel;
                  ROP_XOR:      p.out_color = src ^ r.frame_pixel;
                  ROP_INV_COPY: p.out_color = ~src;
                  default:      p.out_color = src;
               endcase
            end
         end
         pending_rsp.push_back(p);
      endfunction

      function void check_beat(rsp_type got);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected: %p", got);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (got.screen_x !== e.screen_x) begin
            $error("screen_x expected %0d got %0d", e.screen_x, got.screen_x);
            errors++;
         end
         if (got.screen_y !== e.screen_y) begin
            $error("screen_y expected %0d got %0d", e.screen_y, got.screen_y);
            errors++;
         end
         if (got.out_color !== e.out_color) begin
            $error("out_color expected %h got %h", e.out_color, got.out_color);
            errors++;
         end
         if (got.draw !== e.draw) begin
            $error("draw expected %b got %b", e.draw, got.draw);
            errors++;
         end
         if (got.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   req_type     req_data;
   logic        empty;
   logic        pop;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [10:0] csr_wdata;

   blit_scoreboard sb;
   bit no_idle;
   int sent;
   int quiet_cycles;

   scaled_blit_raster_op_unit u_top (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) sb.check_beat(rsp_data);
         pop <= no_idle || ($urandom_range(0, 99) >= 27);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // idle cycles before the beat are drawn one by one, each with a 27 percent chance
   task automatic send(req_type r);
      int n;
      n = 0;
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 27) n++;
      end
      if (n > 0) begin
         push <= 1'b0;
         repeat (n) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      sb.note_beat(r);
      sent++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [10:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      sb.set_reg(idx, d);
   endtask

   // drain the pipe, then reprogram every register
   task automatic load_settings(int w, int h, int tw, int th, bit sc, int mode,
                                int ox, int oy);
      push <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      write_reg(REG_SRC_W, 11'(w));
      write_reg(REG_SRC_H, 11'(h));
      write_reg(REG_TGT_W, 11'(tw));
      write_reg(REG_TGT_H, 11'(th));
      write_reg(REG_SCALE, 11'(sc));
      write_reg(REG_RASTER, 11'(mode));
      write_reg(REG_ORIGIN_X, 11'(ox));
      write_reg(REG_ORIGIN_Y, 11'(oy));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type rand_req(bit op);
      req_type r;
      r.op = op;
      r.load_index = 12'($urandom);
      r.load_pixel = 16'($urandom);
      r.offset_x = 10'($urandom);
      r.offset_y = 10'($urandom);
      r.frame_pixel = 16'($urandom);
      return r;
   endfunction

   // compose beat; a read of a blank entry is preceded by a load there
   task automatic compose(int x, int y);
      req_type     r;
      logic [11:0] a;
      logic [1:0]  st;
      r = rand_req(1'b1);
      r.offset_x = 10'(x);
      r.offset_y = 10'(y);
      if (sb.locate(r, a, st) && !sb.seen[a]) begin
         send('{op: 1'b0, load_index: a, load_pixel: 16'($urandom),
                offset_x: 10'($urandom), offset_y: 10'($urandom),
                frame_pixel: 16'($urandom)});
      end
      send(r);
   endtask

   function automatic int pick_src(int lim);
      int k;
      k = $urandom_range(0, 99);
      if (k < 10) return 0;
      if (k < 20) return $urandom_range(lim + 1, 127);
      if (k < 30) return lim;
      return $urandom_range(1, 12);
   endfunction

   function automatic int pick_tgt(int lim);
      int k;
      k = $urandom_range(0, 99);
      if (k < 8) return $urandom_range(lim + 1, 1023);
      if (k < 14) return 1023;
      if (k < 22) return lim;
      if (k < 28) return 1;
      return $urandom_range(1, 40);
   endfunction

   function automatic int pick_origin();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return -1024;
      if (k == 1) return 1023;
      return $urandom_range(0, 2047) - 1024;
   endfunction

   initial begin
      int w, h, dw, dh, phase;
      sb = new();
      sb.cfg = '0;
      sb.cfg.target_width = 10'd1;
      sb.cfg.target_height = 10'd1;
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_idle = 0;
      sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: a 2x2 image at the far corner, edges and outside points
      load_settings(2, 2, 1, 1, 0, ROP_COPY, -1024, -1024);
      compose(0, 0);
      compose(1, 1);
      compose(1, 0);
      compose(2, 0);
      compose(1023, 1023);
      load_settings(64, 64, 320, 240, 1, ROP_INV_COPY, 1023, 1023);
      compose(319, 239);
      compose(0, 0);
      compose(320, 5);
      load_settings(0, 5, 1, 1, 0, ROP_XOR, 0, 0);
      compose(0, 0);
      load_settings(65, 0, 1, 1, 0, ROP_OR, 0, 0);
      compose(0, 0);
      load_settings(65, 3, 1, 1, 0, ROP_AND, 0, 0);
      compose(0, 0);
      load_settings(3, 65, 321, 1, 1, 7, 0, 0);
      compose(0, 0);
      load_settings(3, 3, 321, 1, 1, ROP_COPY, 0, 0);
      compose(0, 0);
      load_settings(3, 3, 5, 241, 1, ROP_COPY, 0, 0);
      compose(0, 0);

      // random phases of mostly in-rectangle composes over fresh settings
      phase = 0;
      while (sent < ITEM_GOAL) begin
         w = pick_src(MAX_SRC_W);
         h = pick_src(MAX_SRC_H);
         load_settings(w, h, pick_tgt(SCREEN_W), pick_tgt(SCREEN_H), $urandom_range(0, 1),
                       $urandom_range(0, 7), pick_origin(), pick_origin());
         no_idle = (phase >= 6 && phase < 10);
         dw = sb.cfg.scale_enable ? int'(sb.cfg.target_width) : w;
         dh = sb.cfg.scale_enable ? int'(sb.cfg.target_height) : h;
         repeat (50) begin
            case ($urandom_range(0, 9))
               0, 1: send(rand_req(1'b0));
               2:    compose($urandom_range(0, 1023), $urandom_range(0, 1023));
               default: compose($urandom_range(0, dw > 0 ? dw - 1 : 0),
                                $urandom_range(0, dh > 0 ? dh - 1 : 0));
            endcase
         end
         phase++;
      end
      no_idle = 0;
      push <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d beats over %0d settings: %0d composes, %0d drawn",
               sent, phase + 8, sb.composes, sb.draws);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
